>>> rtl/aprm_pkg.sv
package aprm_pkg;

   localparam int COEF_W         = 32;
   localparam int DATA_W         = 32;
   localparam int ADDR_W         = 5;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // register index, word address bits of paddr
   typedef enum logic [2:0] {
      REG_COEF_A  = 3'd0,
      REG_COEF_B  = 3'd1,
      REG_COEF_C  = 3'd2,
      REG_COEF_D  = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5
   } reg_index_type;

   // matrix [a c e; b d f], signed fixed point
   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      logic [COEF_W-1:0] d;
      logic [COEF_W-1:0] e;
      logic [COEF_W-1:0] f;
   } coef_type;

endpackage

>>> rtl/aprm_req_if.sv
interface aprm_req_if #(
   parameter int COORD_BITS = aprm_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-1:0] in_x;
   logic signed [COORD_BITS-1:0] in_y;
   logic [COORD_BITS-1:0]        in_width;
   logic [COORD_BITS-1:0]        in_height;

   modport source (
      output valid, action, in_x, in_y, in_width, in_height,
      input  ready
   );
   modport sink (
      input  valid, action, in_x, in_y, in_width, in_height,
      output ready
   );
endinterface

>>> rtl/aprm_rsp_if.sv
interface aprm_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       out_x;
   logic signed [31:0]       out_y;
   logic [31:0]              out_width;
   logic [31:0]              out_height;
   logic                     saturated;

   modport source (
      output valid, out_x, out_y, out_width, out_height, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_width, out_height, saturated,
      output ready
   );
endinterface

>>> rtl/affine_point_rect_mapper.sv
// affine point and bounding box mapper
// req_if carries one word per point or rectangle: action 0 maps (in_x, in_y)
// through the matrix and rounds to nearest, ties away from zero; action 1
// maps the four corners of the rectangle and returns the enclosing integer
// box (floor of left/top, ceil of right/bottom, width and height from those)
// rsp_if returns exactly one word per request, in order, with saturated set
// whenever a coordinate or size was clamped to 32 bits
// the matrix lives in six csr registers (a, b, c, d, shift x, shift y) at
// byte addresses 0, 4, ... 20; the user must write them over the apb port
// only while idle, the block does not enforce this; the pipe takes one word
// per cycle while the receiver keeps taking words; each word passes in
// order through the six register stages: corner setup, eight parallel
// multipliers, min/max, sum, round, clamp
// reset empties the pipe and loads the identity matrix
// when the receiver stalls, the stages fill up behind the output register
// and bubbles collapse; req_if.ready drops only once every stage is full
module affine_point_rect_mapper #(
   parameter int COORD_BITS = aprm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aprm_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   aprm_req_if.sink                    req_if,
   aprm_rsp_if.source                  rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [aprm_pkg::ADDR_W-1:0] paddr,
   input  logic [aprm_pkg::DATA_W-1:0] pwdata,
   output logic [aprm_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   // 1.0 in the coefficient format
   localparam logic [aprm_pkg::COEF_W-1:0] UNIT = aprm_pkg::COEF_W'(1) << FRAC_BITS;

   aprm_pkg::coef_type      coef_ff, coef_in;
   aprm_pkg::reg_index_type reg_sel;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = aprm_pkg::reg_index_type'(paddr[aprm_pkg::ADDR_W-1:2]);
   // write lands in the access phase
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         case (reg_sel)
            aprm_pkg::REG_COEF_A:  coef_in.a = pwdata;
            aprm_pkg::REG_COEF_B:  coef_in.b = pwdata;
            aprm_pkg::REG_COEF_C:  coef_in.c = pwdata;
            aprm_pkg::REG_COEF_D:  coef_in.d = pwdata;
            aprm_pkg::REG_SHIFT_X: coef_in.e = pwdata;
            aprm_pkg::REG_SHIFT_Y: coef_in.f = pwdata;
            default: ;  // addresses past the last register are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{a: UNIT, b: '0, c: '0, d: UNIT, e: '0, f: '0};
      end else begin
         coef_ff <= coef_in;
      end
   end

   // read back, unused addresses return zero
   always_comb begin
      case (reg_sel)
         aprm_pkg::REG_COEF_A:  prdata = coef_ff.a;
         aprm_pkg::REG_COEF_B:  prdata = coef_ff.b;
         aprm_pkg::REG_COEF_C:  prdata = coef_ff.c;
         aprm_pkg::REG_COEF_D:  prdata = coef_ff.d;
         aprm_pkg::REG_SHIFT_X: prdata = coef_ff.e;
         aprm_pkg::REG_SHIFT_Y: prdata = coef_ff.f;
         default:               prdata = '0;
      endcase
   end

   // datapath: six register stages with per-stage valid
   aprm_pipe #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_pipe (
      .clock  (clock),
      .reset  (reset),
      .coef   (coef_ff),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

>>> rtl/aprm_pipe.sv
module aprm_pipe #(
   parameter int COORD_BITS = aprm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aprm_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  aprm_pkg::coef_type coef,
   aprm_req_if.sink           req_if,
   aprm_rsp_if.source         rsp_if
);

   localparam int STAGES = 6;
   localparam int EW = COORD_BITS + 2;          // x + w, y + h
   localparam int PW = aprm_pkg::COEF_W + EW;   // one product
   localparam int SW = PW + 2;                  // two products plus shift
   localparam int RW = SW + 1;                  // room for rounding bias
   localparam int IW = RW - FRAC_BITS;          // integer part
   localparam int XW = (IW + 1 > 34) ? IW + 1 : 34;

   localparam logic signed [RW-1:0] HALF     = RW'(1) << (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] ONE_LESS = (RW'(1) << FRAC_BITS) - RW'(1);
   localparam logic signed [XW-1:0] S32_MAX  = XW'(64'sh7FFF_FFFF);
   localparam logic signed [XW-1:0] S32_MIN  = XW'(-64'sd2147483648);
   localparam logic signed [XW-1:0] U32_MAX  = XW'(64'sh FFFF_FFFF);

   // flow control: a stage loads when empty or when its successor loads
   logic [STAGES:1] valid_ff, valid_in, en;

   always_comb begin
      en[STAGES] = !valid_ff[STAGES] || rsp_if.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-1:1], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~en) | (valid_in & en);
      end
   end

   assign req_if.ready = en[1];

   // stage 1: corner coordinates
   logic                 s1_act_ff, s1_act_in;
   logic signed [EW-1:0] s1_x0_ff, s1_x0_in, s1_x1_ff, s1_x1_in;
   logic signed [EW-1:0] s1_y0_ff, s1_y0_in, s1_y1_ff, s1_y1_in;

   assign s1_act_in = req_if.action;
   assign s1_x0_in  = EW'(req_if.in_x);
   assign s1_y0_in  = EW'(req_if.in_y);
   assign s1_x1_in  = s1_x0_in + $signed({2'b00, req_if.in_width});
   assign s1_y1_in  = s1_y0_in + $signed({2'b00, req_if.in_height});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_act_ff <= s1_act_in;
         s1_x0_ff  <= s1_x0_in;
         s1_x1_ff  <= s1_x1_in;
         s1_y0_ff  <= s1_y0_in;
         s1_y1_ff  <= s1_y1_in;
      end
   end

   // stage 2: eight products, one per coefficient and coordinate
   logic                 s2_act_ff;
   logic signed [PW-1:0] s2_ax0_ff, s2_ax0_in, s2_ax1_ff, s2_ax1_in;
   logic signed [PW-1:0] s2_cy0_ff, s2_cy0_in, s2_cy1_ff, s2_cy1_in;
   logic signed [PW-1:0] s2_bx0_ff, s2_bx0_in, s2_bx1_ff, s2_bx1_in;
   logic signed [PW-1:0] s2_dy0_ff, s2_dy0_in, s2_dy1_ff, s2_dy1_in;

   assign s2_ax0_in = $signed(coef.a) * s1_x0_ff;
   assign s2_ax1_in = $signed(coef.a) * s1_x1_ff;
   assign s2_cy0_in = $signed(coef.c) * s1_y0_ff;
   assign s2_cy1_in = $signed(coef.c) * s1_y1_ff;
   assign s2_bx0_in = $signed(coef.b) * s1_x0_ff;
   assign s2_bx1_in = $signed(coef.b) * s1_x1_ff;
   assign s2_dy0_in = $signed(coef.d) * s1_y0_ff;
   assign s2_dy1_in = $signed(coef.d) * s1_y1_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_act_ff <= s1_act_ff;
         s2_ax0_ff <= s2_ax0_in;
         s2_ax1_ff <= s2_ax1_in;
         s2_cy0_ff <= s2_cy0_in;
         s2_cy1_ff <= s2_cy1_in;
         s2_bx0_ff <= s2_bx0_in;
         s2_bx1_ff <= s2_bx1_in;
         s2_dy0_ff <= s2_dy0_in;
         s2_dy1_ff <= s2_dy1_in;
      end
   end

   // stage 3: corners cover every x/y pairing, so min and max split per term
   logic                 s3_act_ff;
   logic signed [PW-1:0] s3_lxp_ff, s3_lxp_in, s3_lxq_ff, s3_lxq_in;
   logic signed [PW-1:0] s3_hxp_ff, s3_hxp_in, s3_hxq_ff, s3_hxq_in;
   logic signed [PW-1:0] s3_lyp_ff, s3_lyp_in, s3_lyq_ff, s3_lyq_in;
   logic signed [PW-1:0] s3_hyp_ff, s3_hyp_in, s3_hyq_ff, s3_hyq_in;

   always_comb begin
      // point mode keeps the first corner in the low terms
      s3_lxp_in = (s2_act_ff && s2_ax1_ff < s2_ax0_ff) ? s2_ax1_ff : s2_ax0_ff;
      s3_lxq_in = (s2_act_ff && s2_cy1_ff < s2_cy0_ff) ? s2_cy1_ff : s2_cy0_ff;
      s3_lyp_in = (s2_act_ff && s2_bx1_ff < s2_bx0_ff) ? s2_bx1_ff : s2_bx0_ff;
      s3_lyq_in = (s2_act_ff && s2_dy1_ff < s2_dy0_ff) ? s2_dy1_ff : s2_dy0_ff;
      s3_hxp_in = (s2_ax1_ff > s2_ax0_ff) ? s2_ax1_ff : s2_ax0_ff;
      s3_hxq_in = (s2_cy1_ff > s2_cy0_ff) ? s2_cy1_ff : s2_cy0_ff;
      s3_hyp_in = (s2_bx1_ff > s2_bx0_ff) ? s2_bx1_ff : s2_bx0_ff;
      s3_hyq_in = (s2_dy1_ff > s2_dy0_ff) ? s2_dy1_ff : s2_dy0_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_act_ff <= s2_act_ff;
         s3_lxp_ff <= s3_lxp_in;
         s3_lxq_ff <= s3_lxq_in;
         s3_hxp_ff <= s3_hxp_in;
         s3_hxq_ff <= s3_hxq_in;
         s3_lyp_ff <= s3_lyp_in;
         s3_lyq_ff <= s3_lyq_in;
         s3_hyp_ff <= s3_hyp_in;
         s3_hyq_ff <= s3_hyq_in;
      end
   end

   // stage 4: add terms and translation
   logic                 s4_act_ff;
   logic signed [SW-1:0] s4_lx_ff, s4_lx_in, s4_hx_ff, s4_hx_in;
   logic signed [SW-1:0] s4_ly_ff, s4_ly_in, s4_hy_ff, s4_hy_in;

   assign s4_lx_in = SW'(s3_lxp_ff) + SW'(s3_lxq_ff) + SW'($signed(coef.e));
   assign s4_hx_in = SW'(s3_hxp_ff) + SW'(s3_hxq_ff) + SW'($signed(coef.e));
   assign s4_ly_in = SW'(s3_lyp_ff) + SW'(s3_lyq_ff) + SW'($signed(coef.f));
   assign s4_hy_in = SW'(s3_hyp_ff) + SW'(s3_hyq_ff) + SW'($signed(coef.f));

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_act_ff <= s3_act_ff;
         s4_lx_ff  <= s4_lx_in;
         s4_hx_ff  <= s4_hx_in;
         s4_ly_ff  <= s4_ly_in;
         s4_hy_ff  <= s4_hy_in;
      end
   end

   // stage 5: floor / round on low edge, ceil on high edge
   logic                 s5_act_ff;
   logic signed [IW-1:0] s5_lx_ff, s5_lx_in, s5_hx_ff, s5_hx_in;
   logic signed [IW-1:0] s5_ly_ff, s5_ly_in, s5_hy_ff, s5_hy_in;
   logic signed [RW-1:0] bias_lx, bias_ly, sum_lx, sum_ly, sum_hx, sum_hy;

   always_comb begin
      // round half away from zero: add half, one less when negative
      bias_lx = s4_act_ff ? '0 : HALF - RW'(s4_lx_ff[SW-1]);
      bias_ly = s4_act_ff ? '0 : HALF - RW'(s4_ly_ff[SW-1]);
      sum_lx  = RW'(s4_lx_ff) + bias_lx;
      sum_ly  = RW'(s4_ly_ff) + bias_ly;
      sum_hx  = RW'(s4_hx_ff) + ONE_LESS;
      sum_hy  = RW'(s4_hy_ff) + ONE_LESS;
      s5_lx_in = sum_lx[RW-1:FRAC_BITS];
      s5_ly_in = sum_ly[RW-1:FRAC_BITS];
      s5_hx_in = sum_hx[RW-1:FRAC_BITS];
      s5_hy_in = sum_hy[RW-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_act_ff <= s4_act_ff;
         s5_lx_ff  <= s5_lx_in;
         s5_hx_ff  <= s5_hx_in;
         s5_ly_ff  <= s5_ly_in;
         s5_hy_ff  <= s5_hy_in;
      end
   end

   // stage 6: size and clamping
   logic                 s6_act_ff;
   logic signed [31:0]   s6_x_ff, s6_x_in, s6_y_ff, s6_y_in;
   logic [31:0]          s6_w_ff, s6_w_in, s6_h_ff, s6_h_in;
   logic                 s6_sat_ff, s6_sat_in;
   logic signed [XW-1:0] lx_w, ly_w, dx_w, dy_w;
   logic                 sat_x, sat_y, sat_w, sat_h;

   always_comb begin
      lx_w = XW'(s5_lx_ff);
      ly_w = XW'(s5_ly_ff);
      dx_w = XW'(s5_hx_ff) - lx_w;
      dy_w = XW'(s5_hy_ff) - ly_w;

      sat_x = (lx_w > S32_MAX) || (lx_w < S32_MIN);
      if (lx_w > S32_MAX) begin
         s6_x_in = 32'sh7FFF_FFFF;
      end else if (lx_w < S32_MIN) begin
         s6_x_in = 32'sh8000_0000;
      end else begin
         s6_x_in = lx_w[31:0];
      end

      sat_y = (ly_w > S32_MAX) || (ly_w < S32_MIN);
      if (ly_w > S32_MAX) begin
         s6_y_in = 32'sh7FFF_FFFF;
      end else if (ly_w < S32_MIN) begin
         s6_y_in = 32'sh8000_0000;
      end else begin
         s6_y_in = ly_w[31:0];
      end

      sat_w = s5_act_ff && ((dx_w < 0) || (dx_w > U32_MAX));
      if (!s5_act_ff || dx_w < 0) begin
         s6_w_in = '0;
      end else if (dx_w > U32_MAX) begin
         s6_w_in = 32'hFFFF_FFFF;
      end else begin
         s6_w_in = dx_w[31:0];
      end

      sat_h = s5_act_ff && ((dy_w < 0) || (dy_w > U32_MAX));
      if (!s5_act_ff || dy_w < 0) begin
         s6_h_in = '0;
      end else if (dy_w > U32_MAX) begin
         s6_h_in = 32'hFFFF_FFFF;
      end else begin
         s6_h_in = dy_w[31:0];
      end

      s6_sat_in = sat_x || sat_y || sat_w || sat_h;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_act_ff <= s5_act_ff;
         s6_x_ff   <= s6_x_in;
         s6_y_ff   <= s6_y_in;
         s6_w_ff   <= s6_w_in;
         s6_h_ff   <= s6_h_in;
         s6_sat_ff <= s6_sat_in;
      end
   end

   assign rsp_if.valid      = valid_ff[STAGES];
   assign rsp_if.out_x      = s6_x_ff;
   assign rsp_if.out_y      = s6_y_ff;
   assign rsp_if.out_width  = s6_w_ff;
   assign rsp_if.out_height = s6_h_ff;
   assign rsp_if.saturated  = s6_sat_ff;

   // point words carry no size
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !s6_act_ff |-> rsp_if.out_width == '0 && rsp_if.out_height == '0)
      else $error("point word with nonzero size");

   // an empty output stage means every stage can take a word
   assert property (@(posedge clock) !valid_ff[STAGES] |-> req_if.ready)
      else $error("input stalled with empty output stage");

   // reset empties the pipe
   assert property (@(posedge clock) $past(reset) |-> !rsp_if.valid)
      else $error("output valid right after reset");

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // fixed point helpers, Q16.16 by default
   localparam int          FRAC        = aprm_pkg::FRAC_BITS_DEF;
   localparam longint      HALF_Q      = longint'(1) << (FRAC - 1);
   localparam longint      S32_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint      S32_MIN     = 64'shFFFF_FFFF_8000_0000;
   localparam longint      U32_MAX     = 64'sh0000_0000_FFFF_FFFF;
   localparam logic [31:0] ONE_Q       = 32'h0001_0000;
   localparam logic [31:0] HALF_COEF   = 32'h0000_8000;
   localparam logic [31:0] COEF_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] COEF_MIN    = 32'h8000_0000;

   // first index past the register file, writes there must be dropped
   localparam logic [2:0]  REG_SPARE   = 3'd6;

   localparam int N_DIRECTED    = 23;
   localparam int N_PHASES      = 9;
   localparam int WORDS_PER_PHASE = 72;
   localparam int SETTLE_CYCLES = 12;      // pipe is 6 deep, leave some slack
   localparam int HOLD_AT_WORD  = 320;     // when the long receiver hold-off starts
   localparam int HOLD_CYCLES   = 120;
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum logic {
      ACT_POINT = 1'b0,
      ACT_RECT  = 1'b1
   } action_type;

   typedef enum {
      MTX_IDENTITY, MTX_HALF, MTX_SHEAR, MTX_SAT_HIGH, MTX_SAT_LOW,
      MTX_ZERO, MTX_GENTLE, MTX_QUARTER, MTX_WILD, MTX_MAX, MTX_MIN
   } matrix_type;

   // one request word
   typedef struct packed {
      action_type         act;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
   } shape_type;

   // one response word
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        width;
      logic [31:0]        height;
      logic               sat;
   } box_type;

   // directed row: matrix to load, the word, and the answer where it is obvious
   typedef struct {
      matrix_type  kind;
      action_type  act;
      int          x;
      int          y;
      int          w;
      int          h;
      bit          typed;
      int          ex;
      int          ey;
      int unsigned ew;
      int unsigned eh;
      bit          es;
   } dir_row_type;

   dir_row_type directed_rows [N_DIRECTED] = '{
      // identity after reset: words pass straight through
      '{MTX_IDENTITY, ACT_POINT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
      '{MTX_IDENTITY, ACT_POINT, 32767, -32768, 0, 0, 1, 32767, -32768, 0, 0, 0},
      // sizes ignored in point mode
      '{MTX_IDENTITY, ACT_POINT, -32768, 32767, 65535, 65535, 1, -32768, 32767, 0, 0, 0},
      // degenerate box, a single point
      '{MTX_IDENTITY, ACT_RECT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
      '{MTX_IDENTITY, ACT_RECT, -32768, -32768, 65535, 65535, 1,
        -32768, -32768, 65535, 65535, 0},
      '{MTX_IDENTITY, ACT_RECT, 32767, 32767, 65535, 65535, 1,
        32767, 32767, 65535, 65535, 0},
      // zero width, box is a vertical line
      '{MTX_IDENTITY, ACT_RECT, 100, -200, 0, 50, 1, 100, -200, 0, 50, 0},
      // half scale: ties round away from zero
      '{MTX_HALF, ACT_POINT, 1, 1, 0, 0, 1, 1, 1, 0, 0, 0},
      '{MTX_HALF, ACT_POINT, -1, -3, 0, 0, 1, -1, -2, 0, 0, 0},
      '{MTX_HALF, ACT_POINT, 3, -5, 0, 0, 1, 2, -3, 0, 0, 0},
      // half scale boxes: floor of left/top, ceil of right/bottom
      '{MTX_HALF, ACT_RECT, 1, 1, 1, 1, 1, 0, 0, 1, 1, 0},
      '{MTX_HALF, ACT_RECT, -1, -1, 1, 1, 1, -1, -1, 1, 1, 0},
      // shear with fractional shift
      '{MTX_SHEAR, ACT_POINT, 1000, -2000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{MTX_SHEAR, ACT_RECT, -32768, 32767, 65535, 65535, 0, 0, 0, 0, 0, 0},
      '{MTX_SHEAR, ACT_RECT, 7, 9, 3, 0, 0, 0, 0, 0, 0, 0},
      '{MTX_SHEAR, ACT_POINT, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      // most negative gains, largest shift: clamps high
      '{MTX_SAT_HIGH, ACT_POINT, -32768, -32768, 0, 0, 1,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1},
      '{MTX_SAT_HIGH, ACT_RECT, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      '{MTX_SAT_HIGH, ACT_RECT, -32768, -32768, 65535, 65535, 0, 0, 0, 0, 0, 0},
      '{MTX_SAT_HIGH, ACT_POINT, 0, 0, 0, 0, 1, 32768, 32768, 0, 0, 0},
      // largest gains, most negative shift: clamps low
      '{MTX_SAT_LOW, ACT_POINT, -32768, -32768, 0, 0, 1,
        32'h8000_0000, 32'h8000_0000, 0, 0, 1},
      '{MTX_SAT_LOW, ACT_RECT, 32767, 32767, 65535, 65535, 0, 0, 0, 0, 0, 0},
      '{MTX_SAT_LOW, ACT_POINT, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   // random phases, extremes among them
   matrix_type phase_plan [N_PHASES] = '{
      MTX_GENTLE, MTX_QUARTER, MTX_WILD, MTX_MAX, MTX_GENTLE,
      MTX_ZERO, MTX_MIN, MTX_QUARTER, MTX_IDENTITY
   };

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [aprm_pkg::ADDR_W-1:0] paddr;
   logic [aprm_pkg::DATA_W-1:0] pwdata;
   logic [aprm_pkg::DATA_W-1:0] prdata;
   logic        pready;

   aprm_req_if #(.COORD_BITS(aprm_pkg::COORD_BITS_DEF)) req_ch ();
   aprm_rsp_if rsp_ch ();

   affine_point_rect_mapper uut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // mirror of the matrix as the block should hold it
   aprm_pkg::coef_type active_mtx;
   // boxes still owed by the block, oldest first
   box_type   pending_boxes [$];
   int        error_count;
   int        words_sent;
   int        send_burst;
   int        rsp_hold_left;
   int        cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // fixed point math, exact in 64 bits
   // ---------------------------------------------------------------------------

   function automatic longint floor_q(longint v);
      return v >>> FRAC;
   endfunction

   function automatic longint ceil_q(longint v);
      return -((-v) >>> FRAC);
   endfunction

   // nearest, ties away from zero
   function automatic longint round_q(longint v);
      if (v >= 0) return (v + HALF_Q) >>> FRAC;
      return -(((-v) + HALF_Q) >>> FRAC);
   endfunction

   function automatic logic [31:0] clamp_s32(longint v, inout bit sat);
      if (v > S32_MAX) begin
         sat = 1'b1;
         v = S32_MAX;
      end
      if (v < S32_MIN) begin
         sat = 1'b1;
         v = S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] clamp_u32(longint v, inout bit sat);
      if (v < 0) begin
         sat = 1'b1;
         v = 0;
      end
      if (v > U32_MAX) begin
         sat = 1'b1;
         v = U32_MAX;
      end
      return v[31:0];
   endfunction

   // expected box for one word under matrix m
   function automatic box_type map_shape(shape_type s, aprm_pkg::coef_type m);
      longint a, b, c, d, e, f, x0, y0, x1, y1;
      longint lo_x, hi_x, lo_y, hi_y, fl, ft;
      longint cx [4];
      longint cy [4];
      bit     sat;
      box_type r;
      a = longint'($signed(m.a));
      b = longint'($signed(m.b));
      c = longint'($signed(m.c));
      d = longint'($signed(m.d));
      e = longint'($signed(m.e));
      f = longint'($signed(m.f));
      x0 = longint'($signed(s.x));
      y0 = longint'($signed(s.y));
      x1 = x0 + longint'(s.w);
      y1 = y0 + longint'(s.h);
      sat = 1'b0;
      if (s.act == ACT_POINT) begin
         r.x      = clamp_s32(round_q(a * x0 + c * y0 + e), sat);
         r.y      = clamp_s32(round_q(b * x0 + d * y0 + f), sat);
         r.width  = '0;
         r.height = '0;
      end else begin
         // corners in order: top left, top right, bottom right, bottom left
         for (int i = 0; i < 4; i++) begin
            cx[i] = a * ((i == 1 || i == 2) ? x1 : x0) + c * ((i >= 2) ? y1 : y0) + e;
            cy[i] = b * ((i == 1 || i == 2) ? x1 : x0) + d * ((i >= 2) ? y1 : y0) + f;
         end
         lo_x = cx[0];
         hi_x = cx[0];
         lo_y = cy[0];
         hi_y = cy[0];
         for (int i = 1; i < 4; i++) begin
            if (cx[i] < lo_x) lo_x = cx[i];
            if (cx[i] > hi_x) hi_x = cx[i];
            if (cy[i] < lo_y) lo_y = cy[i];
            if (cy[i] > hi_y) hi_y = cy[i];
         end
         fl = floor_q(lo_x);
         ft = floor_q(lo_y);
         r.x = clamp_s32(fl, sat);
         r.y = clamp_s32(ft, sat);
         // sizes come from the unclamped edges
         r.width  = clamp_u32(ceil_q(hi_x) - fl, sat);
         r.height = clamp_u32(ceil_q(hi_y) - ft, sat);
      end
      r.sat = sat;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic aprm_pkg::coef_type build_matrix(matrix_type kind);
      aprm_pkg::coef_type m;
      m = '0;
      case (kind)
         MTX_IDENTITY: begin
            m.a = ONE_Q;
            m.d = ONE_Q;
         end
         MTX_HALF: begin
            m.a = HALF_COEF;
            m.d = HALF_COEF;
         end
         MTX_SHEAR: begin
            m.a = ONE_Q;
            m.b = -HALF_COEF;
            m.c = HALF_COEF;
            m.d = 32'h0001_8000;
            m.e = 32'h0000_4000;
            m.f = 32'hFFFD_8000;
         end
         MTX_SAT_HIGH: begin
            m = {{4{COEF_MIN}}, {2{COEF_MAX}}};
         end
         MTX_SAT_LOW: begin
            m = {{4{COEF_MAX}}, {2{COEF_MIN}}};
         end
         MTX_ZERO: begin
            m = '0;
         end
         MTX_GENTLE: begin
            // gains within +-4.0, shifts within +-1000.0
            m.a = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            m.b = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            m.c = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            m.d = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            m.e = 32'(int'($urandom_range(0, 2000 * 65536)) - 1000 * 65536);
            m.f = 32'(int'($urandom_range(0, 2000 * 65536)) - 1000 * 65536);
         end
         MTX_QUARTER: begin
            // quarter steps everywhere so rounding ties come up often
            m.a = 32'((int'($urandom_range(0, 32)) - 16) * 16384);
            m.b = 32'((int'($urandom_range(0, 32)) - 16) * 16384);
            m.c = 32'((int'($urandom_range(0, 32)) - 16) * 16384);
            m.d = 32'((int'($urandom_range(0, 32)) - 16) * 16384);
            m.e = 32'((int'($urandom_range(0, 4000)) - 2000) * 16384);
            m.f = 32'((int'($urandom_range(0, 4000)) - 2000) * 16384);
         end
         MTX_WILD: begin
            m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end
         MTX_MAX: begin
            m = {6{COEF_MAX}};
         end
         MTX_MIN: begin
            m = {6{COEF_MIN}};
         end
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] reg_field(aprm_pkg::coef_type m, logic [2:0] idx);
      case (idx)
         aprm_pkg::REG_COEF_A:  return m.a;
         aprm_pkg::REG_COEF_B:  return m.b;
         aprm_pkg::REG_COEF_C:  return m.c;
         aprm_pkg::REG_COEF_D:  return m.d;
         aprm_pkg::REG_SHIFT_X: return m.e;
         aprm_pkg::REG_SHIFT_Y: return m.f;
         default:               return '0;
      endcase
   endfunction

   // idle length: mostly none, some short, a few long, plus runs with no idling
   function automatic int pick_idle(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic shape_type rand_shape();
      shape_type s;
      int pick;
      pick = $urandom_range(0, 9);
      s.act = action_type'($urandom_range(0, 1));
      s.x = 16'($urandom);
      s.y = 16'($urandom);
      s.w = 16'($urandom);
      s.h = 16'($urandom);
      if (pick >= 5 && pick < 8) begin
         // small coordinates, the usual raster case
         s.x = 16'(int'($urandom_range(0, 800)) - 400);
         s.y = 16'(int'($urandom_range(0, 800)) - 400);
         s.w = 16'($urandom_range(0, 300));
         s.h = 16'($urandom_range(0, 300));
      end else if (pick >= 8) begin
         // corners of the input range, empty or full sizes
         s.x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         s.h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      return s;
   endfunction

   // one apb transfer; psel stays up so transfers can run back to back
   task automatic csr_access(input bit is_write, input logic [2:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   // wait until the block owes nothing and the pipe has emptied
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_matrix(aprm_pkg::coef_type m);
      logic [31:0] rd;
      drain();
      for (int k = aprm_pkg::REG_COEF_A; k <= aprm_pkg::REG_SHIFT_Y; k++)
         csr_access(1'b1, 3'(k), reg_field(m, 3'(k)), rd);
      // write past the last register, must not disturb anything
      csr_access(1'b1, REG_SPARE, $urandom, rd);
      active_mtx = m;
      for (int k = aprm_pkg::REG_COEF_A; k <= aprm_pkg::REG_SHIFT_Y; k++) begin
         csr_access(1'b0, 3'(k), '0, rd);
         if (rd !== reg_field(m, 3'(k))) begin
            $display("%0t: csr readback index %0d expected %h actual %h",
                     $time, k, reg_field(m, 3'(k)), rd);
            error_count++;
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // offer one word, log what it must produce once accepted, then idle a while
   task automatic offer_word(shape_type s, bit typed, box_type want);
      int gap;
      req_ch.action    <= s.act;
      req_ch.in_x      <= s.x;
      req_ch.in_y      <= s.y;
      req_ch.in_width  <= s.w;
      req_ch.in_height <= s.h;
      req_ch.valid     <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_boxes.push_back(typed ? want : map_shape(s, active_mtx));
      words_sent++;
      // keep pushing while the receiver holds off so the pipe backs up
      gap = (rsp_hold_left > 0) ? 0 : pick_idle(send_burst);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // response side: compare in order, random stalls, one long hold-off
   // ---------------------------------------------------------------------------

   initial begin
      int      stall_left;
      int      burst_left;
      bit      hold_done;
      box_type got;
      box_type want;
      stall_left    = 0;
      burst_left    = 0;
      hold_done     = 1'b0;
      rsp_hold_left = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = {rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_width,
                   rsp_ch.out_height, rsp_ch.saturated};
            if (pending_boxes.size() == 0) begin
               $display("%0t: response word with nothing pending, actual %h",
                        $time, got);
               error_count++;
            end else begin
               want = pending_boxes.pop_front();
               check_field("out_x", want.x, got.x);
               check_field("out_y", want.y, got.y);
               check_field("out_width", want.width, got.width);
               check_field("out_height", want.height, got.height);
               check_field("saturated", 32'(want.sat), 32'(got.sat));
            end
         end
         // one long hold-off partway through the random part
         if (!hold_done && words_sent >= HOLD_AT_WORD) begin
            hold_done     = 1'b1;
            rsp_hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_idle(burst_left);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d words still pending",
                  $time, CYCLE_LIMIT, pending_boxes.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence: reset, directed table, random phases, wrap up
   // ---------------------------------------------------------------------------

   initial begin
      matrix_type  loaded_kind;
      shape_type   s;
      box_type     want;
      dir_row_type row;

      error_count      = 0;
      words_sent       = 0;
      send_burst       = 0;
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_POINT;
      req_ch.in_x      = '0;
      req_ch.in_y      = '0;
      req_ch.in_width  = '0;
      req_ch.in_height = '0;

      // block comes out of reset with the identity matrix
      active_mtx  = build_matrix(MTX_IDENTITY);
      loaded_kind = MTX_IDENTITY;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, matrix changes only between groups of rows
      for (int n = 0; n < N_DIRECTED; n++) begin
         row = directed_rows[n];
         if (row.kind != loaded_kind) begin
            load_matrix(build_matrix(row.kind));
            loaded_kind = row.kind;
         end
         s.act = row.act;
         s.x   = 16'(row.x);
         s.y   = 16'(row.y);
         s.w   = 16'(row.w);
         s.h   = 16'(row.h);
         want  = {32'(row.ex), 32'(row.ey), 32'(row.ew), 32'(row.eh), row.es};
         offer_word(s, row.typed, want);
      end

      // random phases, each under a fresh matrix
      for (int p = 0; p < N_PHASES; p++) begin
         load_matrix(build_matrix(phase_plan[p]));
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            offer_word(rand_shape(), 1'b0, '0);
      end

      // let every owed word come back, then watch for strays
      drain();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/aprm_pkg.sv
rtl/aprm_req_if.sv
rtl/aprm_rsp_if.sv
rtl/aprm_pipe.sv
rtl/affine_point_rect_mapper.sv
test/testbench.sv
